// File: rtl/half_duplex_uart_with_rx_ring_defines.svh
// assertion macros used by the top-level module
`ifndef HALF_DUPLEX_UART_WITH_RX_RING_DEFINES_SVH
`define HALF_DUPLEX_UART_WITH_RX_RING_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HDU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HDU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hdu_pkg.sv
package hdu_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);

  localparam int BYTE_W = 8;
  localparam int QT_W = 8;
  localparam int TICK_W = 8;
  localparam int QC_W = 6;
  localparam int SHIFT_W = 10;
  localparam int CNT_W = 4;
  localparam int REQ_W = 2;

  localparam int IN_TDATA_W = 16;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [QC_W-1:0] QC_FIRST_SAMPLE = 6'd5;
  localparam logic [QC_W-1:0] QC_LAST_SAMPLE = 6'd33;
  localparam logic [QC_W-1:0] QC_RX_DONE = 6'd35;
  localparam logic [QC_W-1:0] QC_TX_DONE = 6'd40;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE = 2'd0,
    REQ_SEND = 2'd1,
    REQ_READ = 2'd2,
    REQ_PEEK = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX = 2'd1,
    MODE_TX = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUARTER_TICKS = 1'd0,
    CFG_RX_ENABLE = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic rx_line;
    logic fall;
    req_t req;
    logic [BYTE_W-1:0] tx_byte;
  } cmd_t;

  typedef struct packed {
    logic tx_line;
    logic req_accepted;
    logic rx_valid;
    logic [BYTE_W-1:0] rx_data;
    logic [CNT_W-1:0] rx_count;
    logic busy_res;
  } result_t;

endpackage

// File: rtl/half_duplex_uart_with_rx_ring.sv
// Half-duplex 8N1 UART with a 16-slot receive ring (15 bytes usable), stepped by
// one input word per bit-timing tick. Each word carries the sampled receive line,
// a request (none, send byte, pop, peek) and a byte to send; each word yields
// exactly one result word with the transmit line, request status, the ring byte
// for a pop or peek, the ring fill count and a busy flag. Sustained rate is one
// word per clock while the output side takes results: a two-entry command queue
// sits between the front end, which accepts words and finds falling receive
// edges, and the engine, which steps the bit timer, shifter and ring once per
// word from the queue into a one-deep output register. Write quarter_ticks
// (index 0) and rx_enable (index 1) only while no result is outstanding; the
// ring needs no clearing pass after reset.
`include "half_duplex_uart_with_rx_ring_defines.svh"

module half_duplex_uart_with_rx_ring (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // rx_line, tx_byte, zero pad
  input  logic [hdu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [hdu_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tx_line, req_accepted, rx_data, rx_count, busy_res, zero pad
  output logic [hdu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // rx_valid
  output logic [hdu_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic [hdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hdu_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  result_t res;

  hdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .rx_line   (s_axis_tdata[0]),
    .req_type  (s_axis_tuser[REQ_W-1:0]),
    .tx_byte   (s_axis_tdata[BYTE_W:1]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  hdu_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {1'b0, res.busy_res, res.rx_count, res.rx_data,
                         res.req_accepted, res.tx_line};
  assign m_axis_tuser = res.rx_valid;

  `HDU_ASSERT_NXT(a_full_queue_keeps_output, !s_axis_tready, m_axis_tvalid, "queue full without output")
  `HDU_ASSERT_IMP(a_valid_byte_accepted, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[1], "byte without accepted request")
  `HDU_ASSERT_IMP(a_no_byte_zero_data, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[9:2] == 8'd0, "data set without byte")

endmodule

// File: rtl/hdu_front.sv
module hdu_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic rx_line,
  input  logic [hdu_pkg::REQ_W-1:0] req_type,
  input  logic [hdu_pkg::BYTE_W-1:0] tx_byte,
  output logic cmd_valid,
  output hdu_pkg::cmd_t cmd,
  input  logic cmd_pop
);
  import hdu_pkg::*;

  cmd_t q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic last_rx;
  logic push;
  logic pop;
  cmd_t cmd_in;

  // line edge is found here, in item order
  always_comb begin
    cmd_in.rx_line = rx_line;
    cmd_in.fall = last_rx & ~rx_line;
    cmd_in.req = req_t'(req_type);
    cmd_in.tx_byte = tx_byte;
  end

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push = in_valid & in_ready;
  assign cmd_valid = (count != '0);
  assign pop = cmd_pop & cmd_valid;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      last_rx <= 1'b1;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
        last_rx <= rx_line;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10: count <= count + QCNT_W'(1);
        2'b01: count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

// File: rtl/hdu_engine.sv
module hdu_engine (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  hdu_pkg::cmd_t cmd,
  output logic cmd_pop,
  input  logic cfg_we,
  input  logic [hdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic out_valid,
  input  logic out_ready,
  output hdu_pkg::result_t res
);
  import hdu_pkg::*;

  logic [BYTE_W-1:0] store [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [TICK_W-1:0] tick_count;
  logic [QC_W-1:0] quarter_count;
  logic [SHIFT_W-1:0] shift_reg;
  mode_t mode;
  logic line_out;
  logic [QT_W-1:0] quarter_ticks;
  logic rx_enable;

  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [TICK_W-1:0] tick_count_next;
  logic [QC_W-1:0] quarter_count_next;
  logic [SHIFT_W-1:0] shift_reg_next;
  mode_t mode_next;
  logic line_out_next;
  result_t res_next;

  logic was_busy;
  logic [TICK_W:0] tick_sum;
  logic qend;
  logic [QC_W-1:0] qc_inc;
  logic sample;
  logic [PTR_W-1:0] head_inc;
  logic store_we;
  logic [BYTE_W-1:0] tail_byte;
  logic port_on;

  assign cmd_pop = cmd_valid & (~out_valid | out_ready);
  assign tail_byte = store[tail];
  assign port_on = (quarter_ticks != '0);

  always_comb begin
    head_next = head;
    tail_next = tail;
    tick_count_next = tick_count;
    quarter_count_next = quarter_count;
    shift_reg_next = shift_reg;
    mode_next = mode;
    line_out_next = line_out;
    store_we = 1'b0;
    res_next = '0;

    was_busy = (mode == MODE_RX) || (mode == MODE_TX);
    tick_sum = {1'b0, tick_count} + (TICK_W+1)'(1);
    qend = (tick_sum >= {1'b0, quarter_ticks});
    qc_inc = quarter_count + QC_W'(1);
    sample = (qc_inc >= QC_FIRST_SAMPLE) && (qc_inc <= QC_LAST_SAMPLE)
             && (qc_inc[1:0] == 2'b01);
    head_inc = head + PTR_W'(1);

    case (mode)
      MODE_RX: begin
        tick_count_next = qend ? '0 : tick_sum[TICK_W-1:0];
        if (qend) begin
          quarter_count_next = qc_inc;
          if (sample) begin
            shift_reg_next = {1'b0, shift_reg[9], shift_reg[8] | cmd.rx_line,
                              shift_reg[7:1]};
          end
          if (qc_inc >= QC_RX_DONE) begin
            if (head_inc != tail) begin
              store_we = 1'b1;
              head_next = head_inc;
            end
            mode_next = MODE_IDLE;
            quarter_count_next = '0;
          end
        end
      end
      MODE_TX: begin
        tick_count_next = qend ? '0 : tick_sum[TICK_W-1:0];
        if (qend) begin
          quarter_count_next = qc_inc;
          if (qc_inc[1:0] == 2'b00) begin
            if (qc_inc >= QC_TX_DONE) begin
              mode_next = MODE_IDLE;
              quarter_count_next = '0;
              line_out_next = 1'b1;
            end else begin
              shift_reg_next = {1'b0, shift_reg[SHIFT_W-1:1]};
              line_out_next = shift_reg[1];
            end
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if (!was_busy) begin
      case (cmd.req)
        REQ_SEND: begin
          if (port_on) begin
            res_next.req_accepted = 1'b1;
            shift_reg_next = {1'b1, cmd.tx_byte, 1'b0};
            line_out_next = 1'b0;
            mode_next = MODE_TX;
            tick_count_next = '0;
            quarter_count_next = '0;
          end
        end
        REQ_READ, REQ_PEEK: begin
          res_next.req_accepted = 1'b1;
          if (head != tail) begin
            res_next.rx_valid = 1'b1;
            res_next.rx_data = tail_byte;
            if (cmd.req == REQ_READ) begin
              tail_next = tail + PTR_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
      if ((mode_next == MODE_IDLE) && rx_enable && port_on && cmd.fall) begin
        mode_next = MODE_RX;
        tick_count_next = '0;
        quarter_count_next = '0;
        shift_reg_next = '0;
      end
    end

    res_next.tx_line = line_out_next;
    res_next.rx_count = port_on ? CNT_W'(head_next - tail_next) : '0;
    res_next.busy_res = (mode_next == MODE_RX) || (mode_next == MODE_TX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      tick_count <= '0;
      quarter_count <= '0;
      shift_reg <= '0;
      mode <= MODE_IDLE;
      line_out <= 1'b1;
      quarter_ticks <= '0;
      rx_enable <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd_pop | (out_valid & ~out_ready);
      if (cmd_pop) begin
        head <= head_next;
        tail <= tail_next;
        tick_count <= tick_count_next;
        quarter_count <= quarter_count_next;
        shift_reg <= shift_reg_next;
        mode <= mode_next;
        line_out <= line_out_next;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_QUARTER_TICKS: begin
            quarter_ticks <= cfg_data[QT_W-1:0];
            if (cfg_data[QT_W-1:0] == '0) begin
              mode <= MODE_IDLE;
              line_out <= 1'b1;
              tick_count <= '0;
              quarter_count <= '0;
              rx_enable <= 1'b0;
              head <= tail;
            end
          end
          CFG_RX_ENABLE: begin
            rx_enable <= cfg_data[0];
            if (cfg_data[0] && !rx_enable && port_on) begin
              head <= '0;
              tail <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && store_we) begin
      store[head] <= shift_reg_next[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res <= res_next;
    end
  end

endmodule
